// File: rtl/iia_pkg.sv
package iia_pkg;

    localparam int STORE_DEPTH      = 64;
    localparam int INITIAL_CAPACITY = 4;
    localparam int DATA_W           = 32;
    localparam int STEP_W           = 8;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int CNT_W            = $clog2(STORE_DEPTH + 1);
    localparam int GROW_W           = CNT_W + STEP_W;
    localparam int INIT_CAP         = (INITIAL_CAPACITY > STORE_DEPTH) ? STORE_DEPTH :
                                      ((INITIAL_CAPACITY < 1) ? 1 : INITIAL_CAPACITY);
    localparam int PADDR_W          = 3;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_PUSH   = 3'd1,
        OP_REMOVE = 3'd2,
        OP_POP    = 3'd3,
        OP_GET    = 3'd4,
        OP_SET    = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        REG_GROW_MODE = 1'b0,
        REG_GROW_STEP = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DRAIN,
        S_READ,
        S_CAPTURE,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic cap_grow;
        logic idx_load_pos;
        logic idx_load_last;
        logic idx_inc;
        logic idx_dec;
        logic rd_plain;
        logic rd_move_up;
        logic rd_move_dn;
        logic capture;
        logic wr_din;
        logic cnt_inc;
        logic cnt_dec;
        logic finish;
    } iia_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       fail;
        logic       fail_reg;
        logic       shift_needed;
        logic       idx_at_pos;
        logic       idx_at_last;
        logic       idx_at_count;
    } iia_stat_t;

endpackage

// File: rtl/iia_ram.sv
module iia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/iia_ctrl.sv
module iia_ctrl
    import iia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  iia_stat_t stat,
    output iia_cmd_t  cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.fail)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (stat.op) inside
                        OP_INSERT: state_next = stat.shift_needed ? S_SHIFT_UP : S_WRITE;
                        OP_PUSH, OP_SET: state_next = S_WRITE;
                        OP_REMOVE, OP_GET, OP_POP: state_next = S_READ;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                if (stat.idx_at_pos)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_SHIFT_DN:
            begin
                if (stat.idx_at_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (stat.op == OP_INSERT) ? S_WRITE : S_DONE;
            end
            S_READ:
            begin
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                if (stat.op == OP_REMOVE && !stat.idx_at_count)
                begin
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (!stat.fail)
                begin
                    case (stat.op) inside
                        OP_INSERT:
                        begin
                            cmd.cap_grow      = 1'b1;
                            cmd.idx_load_last = 1'b1;
                        end
                        OP_PUSH: cmd.cap_grow = 1'b1;
                        OP_REMOVE, OP_GET: cmd.idx_load_pos = 1'b1;
                        OP_POP: cmd.idx_load_last = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                cmd.rd_move_up = 1'b1;
                cmd.idx_dec    = !stat.idx_at_pos;
            end
            S_SHIFT_DN:
            begin
                cmd.rd_move_dn = 1'b1;
                cmd.idx_inc    = !stat.idx_at_last;
            end
            S_DRAIN: ;
            S_READ:
            begin
                cmd.rd_plain = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            S_CAPTURE:
            begin
                cmd.capture = 1'b1;
            end
            S_WRITE:
            begin
                cmd.wr_din = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                if (!stat.fail_reg)
                begin
                    cmd.cnt_inc = (stat.op == OP_INSERT) || (stat.op == OP_PUSH);
                    cmd.cnt_dec = (stat.op == OP_REMOVE) || (stat.op == OP_POP);
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/iia_dp.sv
module iia_dp
    import iia_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  iia_cmd_t                 cmd,
    output iia_stat_t                stat,
    input  logic [2:0]               opcode,
    input  logic [CNT_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    input  logic                     grow_mode,
    input  logic [STEP_W-1:0]        grow_step,
    output logic                     done,
    output logic signed [DATA_W-1:0] data_out,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         element_total,
    output logic [CNT_W-1:0]         capacity_now
);

    logic [2:0]        op_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [DATA_W-1:0] din_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  cap_next;
    logic              move_pend_reg;
    logic              move_pend_next;
    logic [ADDR_W-1:0] move_addr_reg;
    logic [ADDR_W-1:0] move_addr_next;
    logic [DATA_W-1:0] res_data_reg;
    status_t           res_status_reg;
    logic              done_reg;
    status_t           chk_code;
    logic [STEP_W-1:0] step_eff;
    logic [GROW_W-1:0] cap_sum;
    logic [CNT_W-1:0]  grown_cap;
    logic [CNT_W-1:0]  count_last;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign count_last = count_reg - CNT_W'(1);

    always_comb
    begin
        chk_code = ST_OK;
        case (op_reg) inside
            OP_INSERT:
            begin
                if (pos_reg > count_reg)
                begin
                    chk_code = ST_BOUNDS;
                end
                else if (count_reg >= CNT_W'(STORE_DEPTH))
                begin
                    chk_code = ST_FULL;
                end
            end
            OP_PUSH:
            begin
                if (count_reg >= CNT_W'(STORE_DEPTH))
                begin
                    chk_code = ST_FULL;
                end
            end
            OP_REMOVE, OP_GET, OP_SET:
            begin
                if (pos_reg >= count_reg)
                begin
                    chk_code = ST_BOUNDS;
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                begin
                    chk_code = ST_EMPTY;
                end
            end
            default: ;
        endcase
    end

    // grow once: one step always makes room for a single new element
    always_comb
    begin
        step_eff  = (grow_step == '0) ? STEP_W'(1) : grow_step;
        cap_sum   = grow_mode ? (GROW_W'(cap_reg) + GROW_W'(step_eff))
                              : (GROW_W'(cap_reg) << 1);
        grown_cap = (cap_sum > GROW_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH)
                                                     : cap_sum[CNT_W-1:0];
        cap_next  = cap_reg;
        if (cmd.cap_grow && count_reg == cap_reg && cap_reg < CNT_W'(STORE_DEPTH))
        begin
            cap_next = grown_cap;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_last;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_load_pos)
        begin
            idx_next = pos_reg;
        end
        else if (cmd.idx_load_last)
        begin
            idx_next = count_last;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - CNT_W'(1);
        end
    end

    // a move reads one entry now and writes it to its neighbour next cycle
    assign ram_re         = cmd.rd_plain | cmd.rd_move_up | cmd.rd_move_dn;
    assign ram_raddr      = idx_reg[ADDR_W-1:0];
    assign move_pend_next = cmd.rd_move_up | cmd.rd_move_dn;
    assign move_addr_next = cmd.rd_move_up ? (ram_raddr + ADDR_W'(1))
                                           : (ram_raddr - ADDR_W'(1));

    assign ram_we    = move_pend_reg | cmd.wr_din;
    assign ram_wdata = move_pend_reg ? ram_rdata : din_reg;
    always_comb
    begin
        if (move_pend_reg)
        begin
            ram_waddr = move_addr_reg;
        end
        else if (op_reg == OP_PUSH)
        begin
            ram_waddr = count_reg[ADDR_W-1:0];
        end
        else
        begin
            ram_waddr = pos_reg[ADDR_W-1:0];
        end
    end

    iia_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CNT_W'(INIT_CAP);
            move_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            move_pend_reg <= move_pend_next;
            done_reg      <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            din_reg <= data_in;
        end
        if (cmd.exec)
        begin
            res_status_reg <= chk_code;
            res_data_reg   <= '0;
        end
        else if (cmd.capture)
        begin
            res_data_reg <= ram_rdata;
        end
        idx_reg       <= idx_next;
        move_addr_reg <= move_addr_next;
    end

    assign stat.op           = op_reg;
    assign stat.fail         = (chk_code != ST_OK);
    assign stat.fail_reg     = (res_status_reg != ST_OK);
    assign stat.shift_needed = (pos_reg != count_reg);
    assign stat.idx_at_pos   = (idx_reg == pos_reg);
    assign stat.idx_at_last  = (idx_reg == count_last);
    assign stat.idx_at_count = (idx_reg == count_reg);

    assign done          = done_reg;
    assign data_out      = res_data_reg;
    assign status        = res_status_reg;
    assign element_total = count_reg;
    assign capacity_now  = cap_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_din |-> !move_pend_reg)
        else $error("element write collides with a pending move");

    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("element count above reported capacity");

    a_cap_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg <= CNT_W'(STORE_DEPTH))
        else $error("capacity above storage depth");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < CNT_W'(STORE_DEPTH)))
        else $error("element count grows past storage depth");

endmodule

// File: rtl/indexed_insert_remove_array_core.sv
// Channel   Handshake                     Words
// command   start, busy (start & !busy)   opcode, position, data_in
// result    done (one-cycle strobe)       data_out, status, element_total, capacity_now
// config    APB write access phase        grow_mode @ 0x0, grow_step @ 0x4
//
// Push, set, get and pop move no elements; a rejected command or an unused opcode ends
// without touching the store. Insert moves the elements from the position on, remove
// those after it (up to the storage depth less one), and nothing moves when none lie there.
// The store moves one element a cycle; busy drops as done rises; done cannot be stalled.
// Reset clears the count, the capacity (to its initial value) and the settings;
// stored elements are left as they are.
module indexed_insert_remove_array_core
    import iia_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               opcode,
    input  logic [CNT_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    output logic                     done,
    output logic signed [DATA_W-1:0] data_out,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         element_total,
    output logic [CNT_W-1:0]         capacity_now,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    iia_cmd_t          cmd;
    iia_stat_t         stat;
    logic              grow_mode_reg;
    logic [STEP_W-1:0] grow_step_reg;
    logic              cfg_write;
    reg_index_t        cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_mode_reg <= 1'b0;
            grow_step_reg <= STEP_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GROW_MODE: grow_mode_reg <= pwdata[0];
                REG_GROW_STEP: grow_step_reg <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_GROW_MODE: prdata = {31'b0, grow_mode_reg};
            REG_GROW_STEP: prdata = {{(32 - STEP_W){1'b0}}, grow_step_reg};
            default:       prdata = '0;
        endcase
    end

    iia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    iia_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .position      (position),
        .data_in       (data_in),
        .grow_mode     (grow_mode_reg),
        .grow_step     (grow_step_reg),
        .done          (done),
        .data_out      (data_out),
        .status        (status),
        .element_total (element_total),
        .capacity_now  (capacity_now)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

import iia_pkg::*;

typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  outcome;
    logic [CNT_W-1:0]         total;
    logic [CNT_W-1:0]         room;
} array_word_t;

class shift_array_tracker;
    logic signed [DATA_W-1:0] elems [STORE_DEPTH];
    int                       count;
    int                       room;
    bit                       additive;
    logic [STEP_W-1:0]        step;
    array_word_t              awaited [$];
    int                       accepted;
    int                       checked;
    int                       errors;
    int                       peak;
    int                       outcomes [4];

    function new();
        count    = 0;
        room     = INIT_CAP;
        additive = 1'b0;
        step     = STEP_W'(1);
        accepted = 0;
        checked  = 0;
        errors   = 0;
        peak     = 0;
        foreach (outcomes[i])
            outcomes[i] = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [31:0] v);
        case (idx)
            REG_GROW_MODE: additive = v[0];
            REG_GROW_STEP: step = v[STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // Grow the reported capacity until one more element fits; clamp at the depth.
    function void widen();
        int inc;
        int next;
        inc = (step == 0) ? 1 : int'(step);
        while (count + 1 > room && room < STORE_DEPTH)
        begin
            next = additive ? room + inc : room * 2;
            if (next > STORE_DEPTH)
                next = STORE_DEPTH;
            room = next;
        end
    endfunction

    function void note_command(logic [2:0] op, logic [CNT_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
        array_word_t w;
        int          p;
        p = int'(pos);
        w.value   = '0;
        w.outcome = ST_OK;
        case (op)
            OP_INSERT:
                if (p > count)
                    w.outcome = ST_BOUNDS;
                else if (count >= STORE_DEPTH)
                    w.outcome = ST_FULL;
                else
                begin
                    widen();
                    for (int i = count; i > p; i--)
                        elems[i] = elems[i-1];
                    elems[p] = val;
                    count++;
                end
            OP_PUSH:
                if (count >= STORE_DEPTH)
                    w.outcome = ST_FULL;
                else
                begin
                    widen();
                    elems[count] = val;
                    count++;
                end
            OP_REMOVE:
                if (p >= count)
                    w.outcome = ST_BOUNDS;
                else
                begin
                    w.value = elems[p];
                    for (int i = p + 1; i < count; i++)
                        elems[i-1] = elems[i];
                    count--;
                end
            OP_POP:
                if (count == 0)
                    w.outcome = ST_EMPTY;
                else
                begin
                    count--;
                    w.value = elems[count];
                end
            OP_GET:
                if (p >= count)
                    w.outcome = ST_BOUNDS;
                else
                    w.value = elems[p];
            OP_SET:
                if (p >= count)
                    w.outcome = ST_BOUNDS;
                else
                    elems[p] = val;
            default: ;
        endcase
        w.total = count[CNT_W-1:0];
        w.room  = room[CNT_W-1:0];
        if (count > peak)
            peak = count;
        outcomes[w.outcome]++;
        accepted++;
        awaited.push_back(w);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= 40)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    endfunction

    function void check_word(logic signed [DATA_W-1:0] value, logic [1:0] outcome,
                             logic [CNT_W-1:0] total, logic [CNT_W-1:0] room_seen);
        array_word_t want;
        checked++;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: word with none expected, expected nothing, got %0h/%0d/%0d/%0d",
                         $time, value, outcome, total, room_seen);
            return;
        end
        want = awaited.pop_front();
        if (want.value !== value)
            report("data_out", want.value, value);
        if (want.outcome !== outcome)
            report("status", want.outcome, outcome);
        if (want.total !== total)
            report("element_total", want.total, total);
        if (want.room !== room_seen)
            report("capacity_now", want.room, room_seen);
    endfunction
endclass

module testbench;

    localparam int         CYCLE_LIMIT = 600_000;
    localparam int         ITEM_GOAL   = 1250;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic                     busy;
    logic [2:0]               opcode    = OP_PUSH;
    logic [CNT_W-1:0]         position  = '0;
    logic signed [DATA_W-1:0] data_in   = '0;
    logic                     done;
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic [CNT_W-1:0]         element_total;
    logic [CNT_W-1:0]         capacity_now;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [PADDR_W-1:0]       paddr     = '0;
    logic [31:0]              pwdata    = '0;
    logic [31:0]              prdata;
    logic                     pready;

    shift_array_tracker tracker;
    bit                 steady;
    int                 cycle_count = 0;
    int                 settings_used = 0;

    indexed_insert_remove_array_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d words outstanding", $time, tracker.awaited.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            tracker.check_word(data_out, status, element_total, capacity_now);

    task automatic issue(input logic [2:0] op, input int pos,
                         input logic signed [DATA_W-1:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        position <= pos[CNT_W-1:0];
        data_in  <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(op, pos[CNT_W-1:0], val);
    endtask

    // Drop start and hold until every word has come back and the core is idle.
    task automatic settle();
        start <= 1'b0;
        while (tracker.awaited.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_register(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Steer the element count towards target, with some noise on opcode and index.
    task automatic random_command(input int target);
        int         cnt;
        int         r;
        int         pos;
        logic [2:0] op;
        cnt = tracker.count;
        r   = $urandom_range(99);
        if (r < 8)
            op = 3'($urandom);
        else if (cnt < target && r < 65)
            op = $urandom_range(1) ? OP_INSERT : OP_PUSH;
        else if (cnt > target && r < 65)
            op = $urandom_range(1) ? OP_REMOVE : OP_POP;
        else
            op = 3'($urandom_range(int'(OP_SET)));
        r = $urandom_range(99);
        if (r < 10)
            pos = $urandom_range((1 << CNT_W) - 1);
        else if (r < 15)
            pos = cnt;
        else if (op == OP_INSERT)
            pos = $urandom_range(cnt);
        else
            pos = (cnt > 0) ? $urandom_range(cnt - 1) : 0;
        issue(op, pos, pick_value());
    endtask

    task automatic run_phase(input bit additive, input int step, input int target,
                             input int items);
        settle();
        write_register(REG_GROW_MODE, 32'(additive));
        write_register(REG_GROW_STEP, 32'(step));
        settings_used++;
        steady = ($urandom_range(3) == 0);
        repeat (items)
            random_command(target);
    endtask

    initial
    begin
        tracker = new();
        steady  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store: every index is out of range, pop reports empty
        issue(OP_POP, 0, 0);
        issue(OP_REMOVE, 0, 0);
        issue(OP_GET, 0, 0);
        issue(OP_SET, 0, 32'sh1111_1111);
        issue(OP_INSERT, 1, 32'sh2222_2222);
        // fill past the initial capacity with the value extremes
        issue(OP_INSERT, 0, {1'b1, {(DATA_W-1){1'b0}}});
        issue(OP_PUSH, 0, {1'b0, {(DATA_W-1){1'b1}}});
        issue(OP_PUSH, 0, '1);
        issue(OP_INSERT, 0, '0);
        issue(OP_PUSH, 0, 32'sd1);
        issue(OP_INSERT, 2, 32'sh5555_5555);
        issue(OP_INSERT, 6, 32'shAAAA_AAAA);
        issue(OP_GET, 0, 0);
        issue(OP_GET, 6, 0);
        issue(OP_SET, 3, 32'sh1234_5678);
        issue(OP_GET, 7, 0);
        issue(OP_INSERT, 8, 0);
        issue(OP_REMOVE, 0, 0);
        issue(OP_REMOVE, 2, 0);
        issue(OP_REMOVE, 4, 0);
        issue(OP_GET, (1 << CNT_W) - 1, '1);
        issue(OP_SPARE_LO, 1, '1);
        issue(OP_SPARE_HI, (1 << CNT_W) - 1, '1);
        issue(OP_POP, 0, 0);

        // capacity only grows; walk the additive and doubling growth rules with several steps
        run_phase(1'b1, 0, 12, 60);
        run_phase(1'b1, 1, 18, 60);
        run_phase(1'b1, 5, 28, 80);
        run_phase(1'b0, 5, 40, 80);
        run_phase(1'b1, 255, STORE_DEPTH, 150);
        run_phase(1'b0, 1, 0, 150);
        run_phase(1'b1, 128, STORE_DEPTH, 150);
        while (tracker.accepted < ITEM_GOAL)
            run_phase($urandom_range(1), $urandom_range(255), $urandom_range(STORE_DEPTH), 100);

        settle();
        repeat (STORE_DEPTH + 16) @(posedge clk);

        $display("%0d commands under %0d growth settings, %0d words checked, peak %0d elements",
                 tracker.accepted, settings_used, tracker.checked, tracker.peak);
        $display("outcomes: %0d ok, %0d out of range, %0d empty, %0d full",
                 tracker.outcomes[ST_OK], tracker.outcomes[ST_BOUNDS],
                 tracker.outcomes[ST_EMPTY], tracker.outcomes[ST_FULL]);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: indexed_insert_remove_array_core.f
rtl/iia_pkg.sv
rtl/iia_ram.sv
rtl/iia_ctrl.sv
rtl/iia_dp.sv
rtl/indexed_insert_remove_array_core.sv
tb/sv/testbench.sv
